/* rtl/gse_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants for the grid successor expander.
// No dependencies; gse_if and grid_successor_expander_unit use this package.
package gse_pkg;

    // Operation codes of an input word
    localparam logic OP_LOAD   = 1'b0;
    localparam logic OP_EXPAND = 1'b1;

    // Configuration register indexes
    localparam logic [1:0] CFG_CELL_W   = 2'd0;
    localparam logic [1:0] CFG_CELL_H   = 2'd1;
    localparam logic [1:0] CFG_DIAGONAL = 2'd2;
    localparam logic [1:0] CFG_LIVE     = 2'd3;

    localparam logic [3:0] IMPASSABLE = 4'd9;

    // Neighbor offsets in emit order: left, up, right, down, then diagonals
    localparam logic signed [1:0] DX [8] = '{-2'sd1, 2'sd0, 2'sd1, 2'sd0,
                                             2'sd1, -2'sd1, -2'sd1, 2'sd1};
    localparam logic signed [1:0] DY [8] = '{2'sd0, -2'sd1, 2'sd0, 2'sd1,
                                             2'sd1, 2'sd1, -2'sd1, -2'sd1};

    typedef struct packed {
        logic               operation;
        logic [5:0]         entry_index;
        logic signed [15:0] obstacle_left;
        logic signed [15:0] obstacle_top;
        logic [14:0]        obstacle_width;
        logic [14:0]        obstacle_height;
        logic [3:0]         obstacle_cost;
        logic [31:0]        obstacle_margins;
        logic signed [15:0] node_cell_x;
        logic signed [15:0] node_cell_y;
        logic signed [15:0] parent_cell_x;
        logic signed [15:0] parent_cell_y;
    } in_word_t;

    typedef struct packed {
        logic signed [15:0] successor_x;
        logic signed [15:0] successor_y;
        logic               successor_valid;
        logic [3:0]         node_step_cost;
        logic               last_successor;
    } out_word_t;

    typedef struct packed {
        logic [1:0]  index;
        logic [10:0] value;
    } cfg_word_t;

    // One obstacle entry as held in the entry memory
    typedef struct packed {
        logic signed [15:0] left;
        logic signed [15:0] top;
        logic [14:0]        width;
        logic [14:0]        height;
        logic [31:0]        margins;
        logic [3:0]         cost;
    } entry_t;

endpackage

/* rtl/gse_if.sv */
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the grid successor expander.
// Depends on gse_pkg for the word types.
interface gse_in_if;
    logic             valid;
    logic             ready;
    gse_pkg::in_word_t data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface gse_out_if;
    logic               valid;
    logic               ready;
    gse_pkg::out_word_t data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface gse_cfg_if;
    logic               valid;
    logic               ready;
    gse_pkg::cfg_word_t data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* rtl/grid_successor_expander_unit.sv */
`timescale 1ns / 1ps
// Grid successor expander. A load word writes one obstacle entry into the
// entry RAM in the cycle it is taken; an expand word scans the live entries
// one at a time, snapping each to the grid with four serial dividers that
// run in parallel, and folds its cost into the nine cells around the node.
// Each entry passes through a RAM read, the serial divider steps, a bound
// stage and a cover test; after the last entry the expansion emits its
// result words. One word is worked on at a time. Depends on gse_pkg,
// gse_if, gse_ram and gse_div.
module grid_successor_expander_unit #(
    parameter int MAX_ENTRIES = 64
) (
    input  logic      clk,
    input  logic      rst_n,
    gse_in_if.sink    src_ch,
    gse_out_if.source dst_ch,
    gse_cfg_if.sink   cfg_ch
);
    import gse_pkg::*;

    localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CW = $clog2(MAX_ENTRIES + 1);
    localparam int LW = (CW > 7) ? CW : 7;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_ISSUE = 3'd1;
    localparam logic [2:0] S_READ  = 3'd2;
    localparam logic [2:0] S_DIV   = 3'd3;
    localparam logic [2:0] S_BOUND = 3'd4;
    localparam logic [2:0] S_TEST  = 3'd5;
    localparam logic [2:0] S_MASK  = 3'd6;
    localparam logic [2:0] S_EMIT  = 3'd7;

    // Configuration
    logic [10:0] cell_w_reg, cell_h_reg;
    logic        diag_reg;
    logic [6:0]  live_reg;
    logic [10:0] gw, gh;
    logic [CW-1:0] n_eff;

    // Control and payload state
    logic [2:0]         state_reg, state_next;
    logic [CW-1:0]      idx_reg, idx_next;
    logic signed [15:0] node_x_reg, node_y_reg, par_x_reg, par_y_reg;
    logic [3:0]         best_reg [9];
    logic [3:0]         best_next [9];
    logic [31:0]        marg_reg;
    logic [3:0]         cost_reg;
    logic signed [19:0] x0_reg, x1_reg, y0_reg, y1_reg;
    logic [7:0]         mask_reg, mask_next;
    logic               out_valid_reg, out_valid_next;
    out_word_t          out_reg, out_next;

    // Entry memory
    logic   ram_we;
    entry_t ram_wdata, ram_rdata;
    in_word_t w;

    // Dividers
    logic               div_start;
    logic               busy_l, busy_r, busy_t, busy_b;
    logic signed [17:0] q_l, q_r, q_t, q_b;
    logic signed [17:0] dvd_l, dvd_r, dvd_t, dvd_b;

    // Cover test
    logic [19:0] node20_x, node20_y;
    logic [2:0]  col_ok, row_ok;
    logic        slot_free;
    logic        accept;

    assign w         = src_ch.data;
    assign accept    = src_ch.valid && src_ch.ready;
    assign slot_free = !out_valid_reg || dst_ch.ready;

    // Zero cell size counts as one; live count saturates at the table size
    assign gw    = (cell_w_reg == 11'd0) ? 11'd1 : cell_w_reg;
    assign gh    = (cell_h_reg == 11'd0) ? 11'd1 : cell_h_reg;
    assign n_eff = (LW'(live_reg) >= LW'(MAX_ENTRIES)) ? CW'(MAX_ENTRIES)
                                                      : CW'(live_reg);

    // Configuration writes
    assign cfg_ch.ready = 1'b1;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cell_w_reg <= 11'd32;
            cell_h_reg <= 11'd32;
            diag_reg   <= 1'b0;
            live_reg   <= 7'd0;
        end
        else if (cfg_ch.valid)
        begin
            unique case (cfg_ch.data.index)
                CFG_CELL_W:   cell_w_reg <= cfg_ch.data.value;
                CFG_CELL_H:   cell_h_reg <= cfg_ch.data.value;
                CFG_DIAGONAL: diag_reg   <= cfg_ch.data.value[0];
                CFG_LIVE:     live_reg   <= cfg_ch.data.value[6:0];
                default:      ;
            endcase
        end
    end

    // Loads write only from idle, so no scan read can overlap a write
    assign ram_we          = accept && (w.operation == OP_LOAD)
                             && (32'(w.entry_index) < MAX_ENTRIES);
    assign ram_wdata.left    = w.obstacle_left;
    assign ram_wdata.top     = w.obstacle_top;
    assign ram_wdata.width   = w.obstacle_width;
    assign ram_wdata.height  = w.obstacle_height;
    assign ram_wdata.margins = w.obstacle_margins;
    assign ram_wdata.cost    = (w.obstacle_cost > IMPASSABLE) ? IMPASSABLE
                                                             : w.obstacle_cost;

    gse_ram #(
        .WIDTH ($bits(entry_t)),
        .DEPTH (MAX_ENTRIES)
    ) u_entry_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (AW'(w.entry_index)),
        .wdata (ram_wdata),
        .raddr (idx_reg[AW-1:0]),
        .rdata (ram_rdata)
    );

    // Snap edges: left, left+width, top, top+height over the cell size
    assign div_start = (state_reg == S_READ);
    assign dvd_l = 18'(ram_rdata.left);
    assign dvd_r = 18'(ram_rdata.left) + $signed({3'b000, ram_rdata.width});
    assign dvd_t = 18'(ram_rdata.top);
    assign dvd_b = 18'(ram_rdata.top) + $signed({3'b000, ram_rdata.height});

    gse_div u_div_l (.clk(clk), .rst_n(rst_n), .start(div_start), .dividend(dvd_l),
                     .divisor(gw), .busy(busy_l), .quotient(q_l));
    gse_div u_div_r (.clk(clk), .rst_n(rst_n), .start(div_start), .dividend(dvd_r),
                     .divisor(gw), .busy(busy_r), .quotient(q_r));
    gse_div u_div_t (.clk(clk), .rst_n(rst_n), .start(div_start), .dividend(dvd_t),
                     .divisor(gh), .busy(busy_t), .quotient(q_t));
    gse_div u_div_b (.clk(clk), .rst_n(rst_n), .start(div_start), .dividend(dvd_b),
                     .divisor(gh), .busy(busy_b), .quotient(q_b));

    // Row and column cover of the 3x3 window around the node
    assign node20_x = 20'(node_x_reg);
    assign node20_y = 20'(node_y_reg);
    always_comb
    begin
        logic [19:0] cx, cy;
        for (int j = 0; j < 3; j++)
        begin
            cx = node20_x + 20'(j) - 20'd1;
            cy = node20_y + 20'(j) - 20'd1;
            col_ok[j] = ($signed(cx) >= x0_reg) && ($signed(cx) < x1_reg);
            row_ok[j] = ($signed(cy) >= y0_reg) && ($signed(cy) < y1_reg);
        end
    end

    // Main sequencer
    always_comb
    begin
        logic signed [16:0] sx, sy, px, py;
        logic               found;
        logic [2:0]         pick;
        logic [3:0]         c;
        state_next     = state_reg;
        idx_next       = idx_reg;
        mask_next      = mask_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        found          = 1'b0;
        pick           = 3'd0;
        sx             = '0;
        sy             = '0;
        px             = '0;
        py             = '0;
        c              = '0;
        for (int i = 0; i < 9; i++)
        begin
            best_next[i] = best_reg[i];
        end
        if (out_valid_reg && dst_ch.ready)
        begin
            out_valid_next = 1'b0;
        end
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept && (w.operation == OP_EXPAND))
                begin
                    for (int i = 0; i < 9; i++)
                    begin
                        best_next[i] = 4'd0;
                    end
                    idx_next   = '0;
                    state_next = (n_eff == '0) ? S_MASK : S_ISSUE;
                end
            end
            S_ISSUE: state_next = S_READ;
            S_READ:  state_next = S_DIV;
            S_DIV:
            begin
                if (!busy_l && !busy_r && !busy_t && !busy_b)
                begin
                    state_next = S_BOUND;
                end
            end
            S_BOUND: state_next = S_TEST;
            S_TEST:
            begin
                for (int r = 0; r < 3; r++)
                begin
                    for (int k = 0; k < 3; k++)
                    begin
                        if (row_ok[r] && col_ok[k] && (cost_reg > best_reg[r * 3 + k]))
                        begin
                            best_next[r * 3 + k] = cost_reg;
                        end
                    end
                end
                idx_next   = idx_reg + CW'(1);
                state_next = (idx_next == n_eff) ? S_MASK : S_ISSUE;
            end
            S_MASK:
            begin
                px = 17'(par_x_reg);
                py = 17'(par_y_reg);
                for (int k = 0; k < 8; k++)
                begin
                    sx = 17'(node_x_reg) + 17'(DX[k]);
                    sy = 17'(node_y_reg) + 17'(DY[k]);
                    c  = 4'((DY[k] + 2'sd1) * 3 + (DX[k] + 2'sd1));
                    mask_next[k] = (best_reg[c] < IMPASSABLE)
                                   && !((sx == px) && (sy == py))
                                   && ((k < 4) || diag_reg);
                end
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (slot_free)
                begin
                    for (int k = 7; k >= 0; k--)
                    begin
                        if (mask_reg[k])
                        begin
                            found = 1'b1;
                            pick  = 3'(k);
                        end
                    end
                    out_valid_next          = 1'b1;
                    out_next.node_step_cost = best_reg[4];
                    if (found)
                    begin
                        sx = 17'(node_x_reg) + 17'(DX[pick]);
                        sy = 17'(node_y_reg) + 17'(DY[pick]);
                        mask_next[pick]          = 1'b0;
                        out_next.successor_x     = sx[15:0];
                        out_next.successor_y     = sy[15:0];
                        out_next.successor_valid = 1'b1;
                        out_next.last_successor  = (mask_next == 8'd0);
                    end
                    else
                    begin
                        // Node with no passable neighbor: a single empty word
                        out_next.successor_x     = 16'sd0;
                        out_next.successor_y     = 16'sd0;
                        out_next.successor_valid = 1'b0;
                        out_next.last_successor  = 1'b1;
                    end
                    if (out_next.last_successor)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        mask_reg <= mask_next;
        for (int i = 0; i < 9; i++)
        begin
            best_reg[i] <= best_next[i];
        end
        if (accept)
        begin
            node_x_reg <= w.node_cell_x;
            node_y_reg <= w.node_cell_y;
            par_x_reg  <= w.parent_cell_x;
            par_y_reg  <= w.parent_cell_y;
        end
        if (state_reg == S_READ)
        begin
            marg_reg <= ram_rdata.margins;
            cost_reg <= ram_rdata.cost;
        end
        // Grid bounds widened by the borders
        if (state_reg == S_BOUND)
        begin
            x0_reg <= 20'(q_l) - $signed({12'd0, marg_reg[7:0]});
            x1_reg <= 20'(q_r) + 20'sd1 + $signed({12'd0, marg_reg[15:8]});
            y0_reg <= 20'(q_t) - $signed({12'd0, marg_reg[23:16]});
            y1_reg <= 20'(q_b) + 20'sd1 + $signed({12'd0, marg_reg[31:24]});
        end
    end

    assign src_ch.ready = (state_reg == S_IDLE);
    assign dst_ch.valid = out_valid_reg;
    assign dst_ch.data  = out_reg;
endmodule

/* rtl/gse_ram.sv */
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module gse_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                       clk,
    input  logic                                       we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                           wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                           rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

/* rtl/gse_div.sv */
`timescale 1ns / 1ps
// Serial truncating divider: signed 18-bit dividend by a positive 11-bit
// divisor, one quotient bit per cycle. Depends on nothing but itself.
module gse_div (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic signed [17:0] dividend,
    input  logic [10:0]        divisor,
    output logic               busy,
    output logic signed [17:0] quotient
);
    logic        busy_reg, busy_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic        neg_reg, neg_next;
    logic [16:0] mag_reg, mag_next;
    logic [10:0] rem_reg, rem_next;
    logic [10:0] div_reg, div_next;
    logic [17:0] abs_val;
    logic [11:0] rem_sh;
    logic [11:0] rem_sub;
    logic        ge;

    // Magnitude of the dividend; -131072 never occurs, so 17 bits suffice
    assign abs_val = dividend[17] ? (18'd0 - dividend) : dividend;
    assign rem_sh  = {rem_reg, mag_reg[16]};
    assign rem_sub = rem_sh - {1'b0, div_reg};
    assign ge      = (rem_sh >= {1'b0, div_reg});

    // Restoring division step
    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        neg_next  = neg_reg;
        mag_next  = mag_reg;
        rem_next  = rem_reg;
        div_next  = div_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = 5'd0;
            neg_next  = dividend[17];
            mag_next  = abs_val[16:0];
            rem_next  = 11'd0;
            div_next  = divisor;
        end
        else if (busy_reg)
        begin
            rem_next = ge ? rem_sub[10:0] : rem_sh[10:0];
            mag_next = {mag_reg[15:0], ge};
            cnt_next = cnt_reg + 5'd1;
            if (cnt_reg == 5'd16)
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= 5'd0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        neg_reg <= neg_next;
        mag_reg <= mag_next;
        rem_reg <= rem_next;
        div_reg <= div_next;
    end

    // Quotient rounds toward zero: apply the dividend's sign
    assign busy     = busy_reg;
    assign quotient = neg_reg ? (18'sd0 - $signed({1'b0, mag_reg}))
                              : $signed({1'b0, mag_reg});
endmodule
